/* hdl/sled_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types, character codes and helpers for the string literal decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam int unsigned MAX_LEN   = 65535;
    localparam int          CNT_W     = 16;
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        (MAX_LEN < 65535) ? CNT_W'(MAX_LEN) : CNT_W'(65535);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_X   = 8'h78;

    localparam logic [7:0] VAL_BEL = 8'h07;
    localparam logic [7:0] VAL_BS  = 8'h08;
    localparam logic [7:0] VAL_TAB = 8'h09;
    localparam logic [7:0] VAL_LF  = 8'h0A;
    localparam logic [7:0] VAL_VT  = 8'h0B;
    localparam logic [7:0] VAL_FF  = 8'h0C;
    localparam logic [7:0] VAL_CR  = 8'h0D;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EARLY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_NEWLINE = 2'd3
    } t_status;

    typedef struct packed {
        logic       is_quote;
        logic       is_bslash;
        logic       is_nl;
        logic       is_nul;
        logic       is_x;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       esc_ok;
        logic [7:0] esc_val;
    } t_class;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        t_class     cls;
    } t_item;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_LIMIT) ? v + CNT_W'(1) : CNT_LIMIT;
    endfunction

    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        c.is_quote  = (b == CH_QUOTE);
        c.is_bslash = (b == CH_BSLASH);
        c.is_nl     = (b == CH_NL);
        c.is_nul    = (b == CH_NUL);
        c.is_x      = (b == CH_LO_X);
        c.hex_ok    = 1'b0;
        c.hex_val   = b[3:0];
        if (b >= CH_ZERO && b <= CH_NINE) begin
            c.hex_ok = 1'b1;
        end else if ((b >= CH_LO_A && b <= CH_LO_F) || (b >= CH_UP_A && b <= CH_UP_F)) begin
            c.hex_ok  = 1'b1;
            c.hex_val = b[3:0] + 4'd9;
        end
        c.esc_ok  = 1'b1;
        c.esc_val = b;
        unique case (b)
            CH_QUOTE, CH_APOS, CH_BSLASH: c.esc_val = b;
            CH_ZERO: c.esc_val = CH_NUL;
            CH_LO_A: c.esc_val = VAL_BEL;
            CH_LO_B: c.esc_val = VAL_BS;
            CH_LO_T: c.esc_val = VAL_TAB;
            CH_LO_N: c.esc_val = VAL_LF;
            CH_LO_V: c.esc_val = VAL_VT;
            CH_LO_F: c.esc_val = VAL_FF;
            CH_LO_R: c.esc_val = VAL_CR;
            default: c.esc_ok = 1'b0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/sled_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_front
// Input side: takes source bytes and classifies them for the queue.
// ----------------------------------------------------------------------------
module sled_front
    import sled_pkg::*;
(
    input  wire logic       i_s_tvalid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_first,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_s_tready,
    output logic            o_push,
    output t_item           o_item
);

    assign o_s_tready   = ~i_q_full;
    assign o_push       = i_s_tvalid & ~i_q_full;
    assign o_item.data  = i_byte;
    assign o_item.first = i_first;
    assign o_item.last  = i_last;
    assign o_item.cls   = classify(i_byte);

endmodule
`default_nettype wire

/* hdl/sled_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sled_queue
    import sled_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item
);

    t_item           r_mem [QDEPTH];
    logic [QAW-1:0]  r_wptr;
    logic [QAW-1:0]  r_rptr;
    logic [QAW:0]    r_count;

    logic [QAW:0]    n_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QAW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/sled_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_back
// Decode state machine and output register.
// ----------------------------------------------------------------------------
module sled_back
    import sled_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_q_valid,
    input  wire t_item                   i_item,
    output logic                         o_pop,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]       o_m_tdata,
    output logic [OUT_TUSER_W-1:0]       o_m_tuser
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_BODY = 3'd1,
        M_ESC  = 3'd2,
        M_HEX1 = 3'd3,
        M_HEX2 = 3'd4
    } t_mode;

    t_mode                   r_mode;
    logic [3:0]              r_hex;
    logic [CNT_W-1:0]        r_cons;
    logic [CNT_W-1:0]        r_dec;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_tdata;
    logic [OUT_TUSER_W-1:0]  r_tuser;

    t_mode                   n_mode;
    logic [3:0]              n_hex;
    logic [CNT_W-1:0]        n_cons;
    logic [CNT_W-1:0]        n_dec;
    logic                    n_emit;
    logic                    n_done;
    t_status                 n_status;
    logic [7:0]              n_byte;
    logic [CNT_W-1:0]        n_dec_out;

    assign o_pop      = i_q_valid & (~r_out_valid | i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    always_comb begin
        n_mode   = r_mode;
        n_hex    = r_hex;
        n_cons   = r_cons;
        n_dec    = r_dec;
        n_emit   = 1'b0;
        n_done   = 1'b0;
        n_status = ST_OK;
        n_byte   = '0;
        if (i_item.first) begin
            n_hex  = '0;
            n_dec  = '0;
            n_cons = sat_inc('0);
            if (i_item.last) begin
                n_done   = 1'b1;
                n_status = ST_EARLY;
            end else if (!i_item.cls.is_quote) begin
                n_done   = 1'b1;
                n_status = ST_INVALID;
            end else begin
                n_mode = M_BODY;
            end
        end else begin
            unique case (r_mode)
                M_IDLE: begin
                end
                M_BODY: begin
                    if (i_item.cls.is_nl) begin
                        n_done   = 1'b1;
                        n_status = ST_NEWLINE;
                    end else if (i_item.cls.is_nul) begin
                        n_done   = 1'b1;
                        n_status = ST_INVALID;
                    end else begin
                        n_cons = sat_inc(r_cons);
                        if (i_item.cls.is_quote) begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end else if (i_item.last) begin
                            n_done   = 1'b1;
                            n_status = ST_EARLY;
                        end else if (i_item.cls.is_bslash) begin
                            n_mode = M_ESC;
                        end else begin
                            n_emit = 1'b1;
                            n_byte = i_item.data;
                        end
                    end
                end
                M_ESC: begin
                    n_cons = sat_inc(r_cons);
                    if (i_item.cls.is_x) begin
                        if (i_item.last) begin
                            n_done   = 1'b1;
                            n_status = ST_INVALID;
                        end else begin
                            n_mode = M_HEX1;
                        end
                    end else if (!i_item.cls.esc_ok) begin
                        n_done   = 1'b1;
                        n_status = ST_INVALID;
                    end else if (i_item.last) begin
                        n_done   = 1'b1;
                        n_status = ST_EARLY;
                    end else begin
                        n_mode = M_BODY;
                        n_emit = 1'b1;
                        n_byte = i_item.cls.esc_val;
                    end
                end
                M_HEX1: begin
                    if (!i_item.cls.hex_ok || i_item.last) begin
                        n_done   = 1'b1;
                        n_status = ST_INVALID;
                    end else begin
                        n_hex  = i_item.cls.hex_val;
                        n_mode = M_HEX2;
                    end
                end
                M_HEX2: begin
                    if (!i_item.cls.hex_ok || i_item.last) begin
                        n_done   = 1'b1;
                        n_status = ST_INVALID;
                    end else begin
                        n_cons = sat_inc(sat_inc(r_cons));
                        n_mode = M_BODY;
                        n_emit = 1'b1;
                        n_byte = {r_hex, i_item.cls.hex_val};
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase
        end
        if (n_emit) begin
            n_dec = sat_inc(n_dec);
        end
        if (n_done) begin
            n_mode = M_IDLE;
        end
        n_dec_out = (n_status == ST_OK) ? n_dec : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_hex       <= '0;
            r_cons      <= '0;
            r_dec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode      <= n_mode;
                r_hex       <= n_hex;
                r_cons      <= n_cons;
                r_dec       <= n_dec;
                r_out_valid <= n_emit | n_done;
                if (n_done) begin
                    r_tdata <= {6'b0, n_dec_out, n_cons, n_status, 8'h00};
                    r_tuser <= 2'b10;
                end else begin
                    r_tdata <= {40'b0, n_byte};
                    r_tuser <= 2'b01;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/string_literal_escape_decoder_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_top
// Streaming decoder for double-quoted literals with C-style escapes.
// ----------------------------------------------------------------------------
// Takes one source byte per clock while the queue has room, and gives at
// most one result per byte: a decoded byte, or an end-of-literal report with
// status and the consumed and decoded lengths. A byte passes through the
// four-entry queue behind the classifier and then the output register of
// the decode state machine. With the output side ready the block sustains
// one byte per cycle; a stalled output fills the queue, and the input
// stalls once four requests are waiting.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_top
    import sled_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]   i_s_tdata,   // byte_in
    input  wire logic                    i_s_tuser,   // first
    input  wire logic                    i_s_tlast,   // last
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]       o_m_tdata,   // data_out, status,
                                                      // consumed_length,
                                                      // decoded_length
    output logic [OUT_TUSER_W-1:0]       o_m_tuser    // data_valid, done_res
);

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_item push_item;
    t_item pop_item;

    sled_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_byte     (i_s_tdata),
        .i_first    (i_s_tuser),
        .i_last     (i_s_tlast),
        .i_q_full   (q_full),
        .o_s_tready (o_s_tready),
        .o_push     (push),
        .o_item     (push_item)
    );

    sled_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    sled_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the string literal escape decoder.
// ----------------------------------------------------------------------------
// Feeds literals byte by byte on the input stream and predicts every decoded
// byte and every end-of-literal report in a behavioral copy of the decoder.
// Output results are compared field by field in order. Directed tests cover
// plain bytes, every escape, each error path, restart and a long literal sent
// back to back. A random phase then sends mostly well-formed literals with
// random content, mixed with broken literals and stray bytes. Both stream
// sides stall at random, except during the back-to-back test.
// ----------------------------------------------------------------------------
module tb
    import sled_pkg::*;
();

    typedef enum logic [2:0] {
        LM_IDLE,
        LM_BODY,
        LM_ESC,
        LM_HEX1,
        LM_HEX2
    } t_lit_mode;

    typedef struct {
        logic             dv;
        logic [7:0]       byte_val;
        logic             done;
        t_status          st;
        logic [CNT_W-1:0] cons;
        logic [CNT_W-1:0] dec;
    } t_dec_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // byte_in
    logic                   i_s_tuser;   // first
    logic                   i_s_tlast;   // last
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // data_out, status, consumed_length,
                                         // decoded_length
    logic [OUT_TUSER_W-1:0] o_m_tuser;   // data_valid, done_res

    t_dec_result      decoded_q[$];
    t_lit_mode        lit_mode;
    logic [3:0]       hex_hi;
    logic [CNT_W-1:0] cons_cnt;
    logic [CNT_W-1:0] dec_cnt;
    int               live_bytes;
    int               fail_count;
    bit               steady;

    string_literal_escape_decoder_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
        return (v < CNT_LIMIT) ? v + CNT_W'(1) : CNT_LIMIT;
    endfunction

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] n);
        n = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            n = 4'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_LO_A && c <= CH_LO_F) begin
            n = 4'(c - CH_LO_A + 8'd10);
            return 1'b1;
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            n = 4'(c - CH_UP_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic escape_code(input logic [7:0] c, output logic [7:0] v);
        v = c;
        case (c)
            CH_QUOTE, CH_APOS, CH_BSLASH: v = c;
            CH_ZERO: v = CH_NUL;
            CH_LO_A: v = VAL_BEL;
            CH_LO_B: v = VAL_BS;
            CH_LO_T: v = VAL_TAB;
            CH_LO_N: v = VAL_LF;
            CH_LO_V: v = VAL_VT;
            CH_LO_F: v = VAL_FF;
            CH_LO_R: v = VAL_CR;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int r;
        r = $urandom_range(21);
        if (r < 10) return CH_ZERO + 8'(r);
        if (r < 16) return CH_LO_A + 8'(r - 10);
        return CH_UP_A + 8'(r - 16);
    endfunction

    task automatic close_literal(input t_status st);
        t_dec_result r;
        r.dv       = 1'b0;
        r.byte_val = 8'd0;
        r.done     = 1'b1;
        r.st       = st;
        r.cons     = cons_cnt;
        r.dec      = (st == ST_OK) ? dec_cnt : '0;
        decoded_q.push_back(r);
        lit_mode = LM_IDLE;
    endtask

    task automatic give_byte(input logic [7:0] b);
        t_dec_result r;
        dec_cnt    = sat_bump(dec_cnt);
        r.dv       = 1'b1;
        r.byte_val = b;
        r.done     = 1'b0;
        r.st       = ST_OK;
        r.cons     = '0;
        r.dec      = '0;
        decoded_q.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic f, input logic l);
        logic [7:0] v;
        logic [3:0] n;
        if (f || lit_mode != LM_IDLE) begin
            live_bytes++;
        end
        if (f) begin
            hex_hi   = 4'd0;
            dec_cnt  = '0;
            cons_cnt = sat_bump('0);
            if (l) begin
                close_literal(ST_EARLY);
            end else if (b != CH_QUOTE) begin
                close_literal(ST_INVALID);
            end else begin
                lit_mode = LM_BODY;
            end
            return;
        end
        case (lit_mode)
            LM_BODY: begin
                if (b == CH_NL) begin
                    close_literal(ST_NEWLINE);
                end else if (b == CH_NUL) begin
                    close_literal(ST_INVALID);
                end else begin
                    cons_cnt = sat_bump(cons_cnt);
                    if (b == CH_QUOTE) begin
                        close_literal(ST_OK);
                    end else if (b == CH_BSLASH) begin
                        if (l) close_literal(ST_EARLY);
                        else lit_mode = LM_ESC;
                    end else if (l) begin
                        close_literal(ST_EARLY);
                    end else begin
                        give_byte(b);
                    end
                end
            end
            LM_ESC: begin
                cons_cnt = sat_bump(cons_cnt);
                if (b == CH_LO_X) begin
                    if (l) close_literal(ST_INVALID);
                    else lit_mode = LM_HEX1;
                end else if (!escape_code(b, v)) begin
                    close_literal(ST_INVALID);
                end else if (l) begin
                    close_literal(ST_EARLY);
                end else begin
                    lit_mode = LM_BODY;
                    give_byte(v);
                end
            end
            LM_HEX1: begin
                if (!hex_digit(b, n) || l) begin
                    close_literal(ST_INVALID);
                end else begin
                    hex_hi   = n;
                    lit_mode = LM_HEX2;
                end
            end
            LM_HEX2: begin
                if (!hex_digit(b, n) || l) begin
                    close_literal(ST_INVALID);
                end else begin
                    cons_cnt = sat_bump(sat_bump(cons_cnt));
                    lit_mode = LM_BODY;
                    give_byte({hex_hi, n});
                end
            end
            default: lit_mode = LM_IDLE;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 17);
    end

    always @(posedge i_clk) begin
        t_dec_result w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unrequested result", 64'(o_m_tdata), 64'd0);
            end else begin
                w = decoded_q.pop_front();
                if (o_m_tuser[0] !== w.dv)
                    report_mismatch("data_valid", 64'(o_m_tuser[0]), 64'(w.dv));
                if (o_m_tuser[1] !== w.done)
                    report_mismatch("done_res", 64'(o_m_tuser[1]), 64'(w.done));
                if (o_m_tdata[7:0] !== w.byte_val)
                    report_mismatch("data_out", 64'(o_m_tdata[7:0]), 64'(w.byte_val));
                if (o_m_tdata[9:8] !== w.st)
                    report_mismatch("status", 64'(o_m_tdata[9:8]), 64'(w.st));
                if (o_m_tdata[25:10] !== w.cons)
                    report_mismatch("consumed_length", 64'(o_m_tdata[25:10]),
                                    64'(w.cons));
                if (o_m_tdata[41:26] !== w.dec)
                    report_mismatch("decoded_length", 64'(o_m_tdata[41:26]),
                                    64'(w.dec));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        if (!steady) begin
            while ($urandom_range(99) < 17) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= f;
        i_s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(b, f, l);
    endtask

    task automatic send_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == 0, end_last && i == s.len() - 1);
        end
    endtask

    task automatic test_plain_bytes();
        send_byte(CH_QUOTE, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(CH_QUOTE, 1'b0, 1'b1);
    endtask

    task automatic test_escapes();
        send_text("\"\\\"\\'\\\\\\0\\a\\b\\t\\n\\v\\f\\r\\x4f\\xA0\"", 1'b0);
    endtask

    task automatic test_errors();
        send_byte(CH_QUOTE, 1'b1, 1'b1);
        send_text("A", 1'b0);
        send_text("B", 1'b0);
        send_text("\"a\n", 1'b0);
        send_text("\"", 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b0);
        send_text("\"\\u", 1'b0);
        send_text("\"\\U", 1'b0);
        send_text("\"\\", 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b0);
        send_text("\"\\xg", 1'b0);
        send_text("\"\\x", 1'b1);
        send_text("\"\\x41", 1'b1);
        send_text("\"\\", 1'b1);
        send_text("\"\\n", 1'b1);
        send_text("\"ab", 1'b1);
    endtask

    task automatic test_restart();
        send_text("\"ab", 1'b0);
        send_text("\"c\"", 1'b0);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        send_byte(CH_QUOTE, 1'b1, 1'b0);
        repeat (200) send_byte(8'($urandom_range(35, 91)), 1'b0, 1'b0);
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_LO_X, 1'b0, 1'b0);
        send_byte(rand_hex_char(), 1'b0, 1'b0);
        send_byte(rand_hex_char(), 1'b0, 1'b0);
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_LO_T, 1'b0, 1'b0);
        send_byte(CH_QUOTE, 1'b0, 1'b0);
        steady = 1'b0;
    endtask

    task automatic test_random_literals(input int target);
        logic [7:0] esc_set[11] = '{CH_QUOTE, CH_APOS, CH_BSLASH, CH_ZERO, CH_LO_A,
                                    CH_LO_B, CH_LO_T, CH_LO_N, CH_LO_V, CH_LO_F, CH_LO_R};
        logic [7:0] seq[$];
        logic [7:0] c;
        int         stop_at;
        int         ntok;
        int         r;
        bit         mark_last;
        int         goal;
        goal = live_bytes + target;
        while (live_bytes < goal) begin
            seq.delete();
            seq.push_back(($urandom_range(99) < 96) ? CH_QUOTE : 8'($urandom_range(255)));
            ntok = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
            repeat (ntok) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    do c = 8'($urandom_range(1, 255));
                    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_NL);
                    seq.push_back(c);
                end else if (r < 75) begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(esc_set[$urandom_range(10)]);
                end else if (r < 88) begin
                    seq.push_back(CH_BSLASH);
                    seq.push_back(CH_LO_X);
                    seq.push_back(($urandom_range(99) < 92) ? rand_hex_char()
                                                          : 8'($urandom_range(255)));
                    seq.push_back(($urandom_range(99) < 92) ? rand_hex_char()
                                                          : 8'($urandom_range(255)));
                end else if (r < 93) begin
                    seq.push_back(CH_BSLASH);
                    case ($urandom_range(3))
                        0: seq.push_back(8'h75);
                        1: seq.push_back(8'h55);
                        2: seq.push_back(CH_NUL);
                        default: seq.push_back(8'($urandom_range(255)));
                    endcase
                end else if (r < 96) begin
                    seq.push_back(CH_NL);
                end else if (r < 98) begin
                    seq.push_back(CH_NUL);
                end else begin
                    seq.push_back(8'($urandom_range(128, 255)));
                end
            end
            if ($urandom_range(99) < 92) seq.push_back(CH_QUOTE);
            stop_at   = seq.size() - 1;
            mark_last = 1'b0;
            r = $urandom_range(99);
            if (r < 15) begin
                stop_at   = $urandom_range(seq.size() - 1);
                mark_last = 1'b1;
            end else if (r < 20) begin
                stop_at = $urandom_range(seq.size() - 1);
            end
            for (int i = 0; i <= stop_at; i++) begin
                send_byte(seq[i], i == 0, mark_last && i == stop_at);
            end
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;
        i_s_tlast  <= 1'b0;
        steady      = 1'b0;
        fail_count  = 0;
        live_bytes  = 0;
        lit_mode    = LM_IDLE;
        hex_hi      = 4'd0;
        cons_cnt    = '0;
        dec_cnt     = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_bytes();
        test_escapes();
        test_errors();
        test_restart();
        test_back_to_back();
        test_random_literals(950);

        i_s_tvalid <= 1'b0;
        for (int i = 0; i < 20000 && decoded_q.size() != 0; i++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && decoded_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
hdl/sled_pkg.sv
hdl/sled_front.sv
hdl/sled_queue.sv
hdl/sled_back.sv
hdl/string_literal_escape_decoder_top.sv
test/tb.sv
